// ----- sv/u2g_pkg.sv -----
// Shared types and constants for the UTF-8 to glyph stream converter.
// Used by the front end, the engine and the top level; depends on nothing.
package u2g_pkg;

	localparam int NUM_NORDIC    = 6;
	localparam int WIN_DEPTH     = 4;
	localparam int GLYPH_COUNT_W = 16;
	localparam int MAX_GLYPHS_W  = 16;
	localparam int CP_W          = 21;

	typedef enum logic [2:0] {
		REG_NORDIC_ENABLE      = 3'd0,
		REG_MAX_GLYPHS         = 3'd1,
		REG_GLYPH_A_UMLAUT     = 3'd2,
		REG_GLYPH_O_UMLAUT     = 3'd3,
		REG_GLYPH_A_RING       = 3'd4,
		REG_GLYPH_CAP_A_UMLAUT = 3'd5,
		REG_GLYPH_CAP_O_UMLAUT = 3'd6,
		REG_GLYPH_CAP_A_RING   = 3'd7
	} reg_index_t;

	localparam logic [7:0] GLYPH_UNKNOWN = 8'h3F;
	localparam logic [7:0] BYTE_TERM     = 8'h00;

	localparam logic [CP_W-1:0] NORDIC_CP [NUM_NORDIC] = '{
		21'h0000E4, 21'h0000F6, 21'h0000E5, 21'h0000C4, 21'h0000D6, 21'h0000C5
	};
	localparam logic [7:0] NORDIC_PLAIN [NUM_NORDIC] = '{
		8'h61, 8'h6F, 8'h61, 8'h41, 8'h4F, 8'h41
	};

	typedef struct packed {
		logic [7:0] data;
		logic       term;
		logic       cont;
		logic [2:0] len;
	} in_entry_t;

	typedef struct packed {
		logic                           nordic_enable;
		logic [MAX_GLYPHS_W-1:0]        max_glyphs;
		logic [NUM_NORDIC-1:0][7:0]     glyph_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0]               glyph;
		logic                     is_terminator;
		logic [GLYPH_COUNT_W-1:0] glyph_count;
	} result_t;

endpackage

// ----- sv/u2g_fifo.sv -----
// Small first-word-fall-through queue of fixed-width requests.
// Standalone; used for the input and result queues of the converter.
module u2g_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/u2g_front.sv -----
// Front end: classifies incoming bytes (terminator, continuation, lead length)
// and queues them for the engine. Depends on u2g_pkg and u2g_fifo.
module u2g_front #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           data_byte,
	output logic                 full,
	input  logic                 pop,
	output u2g_pkg::in_entry_t   entry,
	output logic                 empty
);

	u2g_pkg::in_entry_t                      cls;
	logic [$bits(u2g_pkg::in_entry_t)-1:0]   rd_vec;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		if ((b & 8'hE0) == 8'hC0) begin
			n = 3'd2;
		end else if ((b & 8'hF0) == 8'hE0) begin
			n = 3'd3;
		end else if ((b & 8'hF8) == 8'hF0) begin
			n = 3'd4;
		end
		return n;
	endfunction

	always_comb begin
		cls.data = data_byte;
		cls.term = (data_byte == u2g_pkg::BYTE_TERM);
		cls.cont = ((data_byte & 8'hC0) == 8'h80);
		cls.len  = lead_len(data_byte);
	end

	u2g_fifo #(
		.W     ($bits(u2g_pkg::in_entry_t)),
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (pop),
		.rdata  (rd_vec),
		.empty  (empty)
	);

	assign entry = u2g_pkg::in_entry_t'(rd_vec);

endmodule

// ----- sv/u2g_engine.sv -----
// Back end: holds the pending byte window, decodes one code point per cycle unless fetching
// or held by a full result queue, maps it to a glyph and closes strings. Depends on u2g_pkg.
module u2g_engine #(
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u2g_pkg::cfg_t        cfg,
	input  logic                 q_empty,
	input  u2g_pkg::in_entry_t   q_entry,
	output logic                 q_pop,
	input  logic                 out_full,
	output logic                 out_push,
	output u2g_pkg::result_t     out_res
);

	typedef enum logic [1:0] {
		ST_FETCH = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	state_t                  state_q, state_d;
	logic [2:0]              win_cnt_q, win_cnt_d;
	logic                    term_q, term_d;
	logic [COUNT_BITS-1:0]   gw_q, gw_d;

	logic [7:0]              win_byte_q [u2g_pkg::WIN_DEPTH];
	logic                    win_cont_q [u2g_pkg::WIN_DEPTH];
	logic [2:0]              win_len_q  [u2g_pkg::WIN_DEPTH];

	logic [COUNT_BITS-1:0]   limit;
	logic                    at_limit;
	logic [2:0]              len;
	logic                    bad;
	logic                    short_seq;
	logic                    wait_more;
	logic                    do_decode;
	logic [u2g_pkg::CP_W-1:0] cp;
	logic [2:0]              used;
	logic [7:0]              glyph;
	logic                    shift_en;
	logic                    append_en;
	logic [1:0]              append_idx;
	logic [2:0]              base;
	logic [2:0]              src [u2g_pkg::WIN_DEPTH];

	assign limit = (cfg.max_glyphs > u2g_pkg::MAX_GLYPHS_W'(CountMax))
		? CountMax : cfg.max_glyphs[COUNT_BITS-1:0];
	assign at_limit = (gw_q >= limit);

	always_comb begin
		len       = win_len_q[0];
		bad       = 1'b0;
		for (int i = 1; i < u2g_pkg::WIN_DEPTH; i++) begin
			if (3'(i) < len && 3'(i) < win_cnt_q && !win_cont_q[i]) begin
				bad = 1'b1;
			end
		end
		short_seq = (win_cnt_q < len);
		wait_more = (len != 3'd0) && !bad && short_seq && !term_q;
		do_decode = (len != 3'd0) && !bad && !short_seq;

		case (len)
			3'd2: cp = u2g_pkg::CP_W'({win_byte_q[0][4:0], win_byte_q[1][5:0]});
			3'd3: cp = u2g_pkg::CP_W'({win_byte_q[0][3:0], win_byte_q[1][5:0],
				win_byte_q[2][5:0]});
			3'd4: cp = u2g_pkg::CP_W'({win_byte_q[0][2:0], win_byte_q[1][5:0],
				win_byte_q[2][5:0], win_byte_q[3][5:0]});
			default: cp = u2g_pkg::CP_W'(win_byte_q[0]);
		endcase
		if (!do_decode) begin
			cp = u2g_pkg::CP_W'(win_byte_q[0]);
		end
		used = do_decode ? len : 3'd1;

		glyph = u2g_pkg::GLYPH_UNKNOWN;
		if (cp < u2g_pkg::CP_W'(8'h80)) begin
			glyph = cp[7:0];
		end else begin
			for (int k = 0; k < u2g_pkg::NUM_NORDIC; k++) begin
				if (cp == u2g_pkg::NORDIC_CP[k]) begin
					glyph = cfg.nordic_enable ? cfg.glyph_code[k] : u2g_pkg::NORDIC_PLAIN[k];
				end
			end
		end

		for (int k = 0; k < u2g_pkg::WIN_DEPTH; k++) begin
			src[k] = 3'(k) + used;
		end
	end

	always_comb begin
		state_d    = state_q;
		win_cnt_d  = win_cnt_q;
		term_d     = term_q;
		gw_d       = gw_q;
		q_pop      = 1'b0;
		out_push   = 1'b0;
		out_res    = '0;
		shift_en   = 1'b0;
		append_en  = 1'b0;
		base       = win_cnt_q;
		append_idx = win_cnt_q[1:0];

		case (state_q)
			ST_FETCH: begin
				base = win_cnt_q;
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ST_RUN;
					if (q_entry.term) begin
						term_d = 1'b1;
					end else begin
						append_en  = 1'b1;
						append_idx = base[1:0];
						win_cnt_d  = base + 3'd1;
					end
				end
			end
			ST_RUN: begin
				if (win_cnt_q != 3'd0 && !at_limit && !wait_more) begin
					if (!out_full) begin
						out_push        = 1'b1;
						out_res.glyph   = glyph;
						gw_d            = gw_q + 1'b1;
						shift_en        = 1'b1;
						win_cnt_d       = win_cnt_q - used;
					end
				end else if (term_q) begin
					if (!out_full) begin
						out_push              = 1'b1;
						out_res.is_terminator = 1'b1;
						out_res.glyph_count   = u2g_pkg::GLYPH_COUNT_W'(gw_q);
						gw_d                  = '0;
						win_cnt_d             = 3'd0;
						term_d                = 1'b0;
						state_d               = ST_FETCH;
					end
				end else begin
					base      = at_limit ? 3'd0 : win_cnt_q;
					win_cnt_d = base;
					if (q_empty) begin
						state_d = ST_FETCH;
					end else begin
						q_pop = 1'b1;
						if (q_entry.term) begin
							term_d = 1'b1;
						end else begin
							append_en  = 1'b1;
							append_idx = base[1:0];
							win_cnt_d  = base + 3'd1;
						end
					end
				end
			end
			default: begin
				state_d = ST_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (append_en) begin
			win_byte_q[append_idx] <= q_entry.data;
			win_cont_q[append_idx] <= q_entry.cont;
			win_len_q[append_idx]  <= q_entry.len;
		end else if (shift_en) begin
			for (int k = 0; k < u2g_pkg::WIN_DEPTH; k++) begin
				if (src[k] < 3'(u2g_pkg::WIN_DEPTH)) begin
					win_byte_q[k] <= win_byte_q[src[k][1:0]];
					win_cont_q[k] <= win_cont_q[src[k][1:0]];
					win_len_q[k]  <= win_len_q[src[k][1:0]];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FETCH;
			win_cnt_q <= 3'd0;
			term_q    <= 1'b0;
			gw_q      <= '0;
		end else begin
			state_q   <= state_d;
			win_cnt_q <= win_cnt_d;
			term_q    <= term_d;
			gw_q      <= gw_d;
		end
	end

endmodule

// ----- sv/utf8_to_glyph_stream_top.sv -----
// Top level of the UTF-8 to glyph stream converter: configuration registers,
// input front end, decode engine and result queue.
// Depends on u2g_pkg, u2g_front, u2g_engine and u2g_fifo.
// Usage:
//   Input channel: present data_byte with push; a byte is taken at a clock
//   edge where push is high and full is low. 0x00 closes the string.
//   Result channel: while empty is low, glyph/is_terminator/glyph_count show
//   the oldest result; pop at a clock edge with empty low takes it.
//   Each string ends with one terminator result carrying the glyph count.
//   Configuration: cfg_wr_en, cfg_index, cfg_data write one register per edge;
//   write only while no string is in flight.
// Timing:
//   A byte taken at the input passes the registered input queue before the
//   engine sees it. The engine emits glyphs and takes bytes from the input
//   queue in separate cycles, and closes a string with its terminator result
//   apart from taking the 0x00 byte. With the engine idle, a result passes the
//   input queue, the engine window and the result queue before it shows. The
//   single decode engine sets the rate.
// Reset clears all queues, the pending window and the glyph count; registers
// return to their defaults. A stalled receiver fills the result queue, then
// the engine holds, then the input queue fills and full rises.
module utf8_to_glyph_stream_top #(
	parameter int COUNT_BITS = 16,
	parameter int IN_DEPTH   = 4,
	parameter int OUT_DEPTH  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  glyph,
	output logic        is_terminator,
	output logic [15:0] glyph_count,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	u2g_pkg::cfg_t                         cfg_q;
	u2g_pkg::in_entry_t                    q_entry;
	logic                                  q_empty;
	logic                                  q_pop;
	logic                                  out_full;
	logic                                  out_push;
	u2g_pkg::result_t                      out_res;
	logic [$bits(u2g_pkg::result_t)-1:0]   res_vec;
	u2g_pkg::result_t                      res_head;
	logic [2:0]                            glyph_slot;

	assign glyph_slot = cfg_index - 3'(u2g_pkg::REG_GLYPH_A_UMLAUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nordic_enable <= 1'b0;
			cfg_q.max_glyphs    <= 16'd255;
			cfg_q.glyph_code    <= {u2g_pkg::NUM_NORDIC{u2g_pkg::GLYPH_UNKNOWN}};
		end else if (cfg_wr_en) begin
			case (cfg_index)
				u2g_pkg::REG_NORDIC_ENABLE: cfg_q.nordic_enable <= cfg_data[0];
				u2g_pkg::REG_MAX_GLYPHS:    cfg_q.max_glyphs    <= cfg_data;
				default:                    cfg_q.glyph_code[glyph_slot] <= cfg_data[7:0];
			endcase
		end
	end

	u2g_front #(
		.DEPTH (IN_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.full      (full),
		.pop       (q_pop),
		.entry     (q_entry),
		.empty     (q_empty)
	);

	u2g_engine #(
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_res  (out_res)
	);

	u2g_fifo #(
		.W     ($bits(u2g_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_vec),
		.empty  (empty)
	);

	assign res_head      = u2g_pkg::result_t'(res_vec);
	assign glyph         = res_head.glyph;
	assign is_terminator = res_head.is_terminator;
	assign glyph_count   = res_head.glyph_count;

`ifndef SYNTHESIS
	a_term_glyph_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_terminator) |-> (glyph == 8'h00))
		else $error("terminator request carries a nonzero glyph");

	a_count_only_on_term: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_terminator) |-> (glyph_count == 16'h0000))
		else $error("glyph request carries a nonzero count");

	a_limit_written: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && cfg_index == u2g_pkg::REG_MAX_GLYPHS)
		|=> (cfg_q.max_glyphs == $past(cfg_data)))
		else $error("glyph limit register not updated");
`endif

endmodule

// ----- tb/utf8_to_glyph_stream_top_test.sv -----
// Testbench for utf8_to_glyph_stream_top: directed and random byte strings, checked
// against a cycle-free model of the UTF-8 decode, glyph mapping and glyph limit.
// Depends on u2g_pkg and the RTL of the block.
module utf8_to_glyph_stream_top_test;

	localparam logic [20:0] NORDIC_POINTS [6] = '{
		21'h0000E4, 21'h0000F6, 21'h0000E5, 21'h0000C4, 21'h0000D6, 21'h0000C5
	};
	localparam logic [7:0] PLAIN_LETTERS [6] = '{8'h61, 8'h6F, 8'h61, 8'h41, 8'h4F, 8'h41};
	localparam logic [7:0] QUESTION_MARK = 8'h3F;
	localparam logic [7:0] END_OF_STRING = 8'h00;
	localparam int SETTLE_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        empty;
	logic        pop;
	logic [7:0]  glyph;
	logic        is_terminator;
	logic [15:0] glyph_count;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	logic            nordic_on;
	logic [15:0]     glyph_limit;
	logic [5:0][7:0] glyph_codes;
	logic [7:0]      held_bytes [3];
	int              held_count;
	logic [15:0]     glyph_total;

	u2g_pkg::result_t glyphs_due [$];
	int               bad_results;
	int               bytes_sent;
	int               send_gap_max;
	int               pop_gap_max;
	int               pop_wait;

	utf8_to_glyph_stream_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.empty(empty),
		.pop(pop),
		.glyph(glyph),
		.is_terminator(is_terminator),
		.glyph_count(glyph_count),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] glyph_of(logic [20:0] cp);
		if (cp < 21'h80)
			return cp[7:0];
		for (int i = 0; i < 6; i++)
			if (cp == NORDIC_POINTS[i])
				return nordic_on ? glyph_codes[i] : PLAIN_LETTERS[i];
		return QUESTION_MARK;
	endfunction

	function automatic int lead_length(logic [7:0] c);
		if (c[7:5] == 3'b110) return 2;
		if (c[7:4] == 4'b1110) return 3;
		if (c[7:3] == 5'b11110) return 4;
		return 0;
	endfunction

	task automatic decode_byte(input logic [7:0] b);
		logic [7:0]       win [4];
		int               n, pos, avail, len, used;
		logic             ok, term;
		logic [20:0]      cp;
		u2g_pkg::result_t r;
		term = (b == END_OF_STRING);
		n = held_count;
		pos = 0;
		for (int i = 0; i < 3; i++)
			win[i] = held_bytes[i];
		if (!term) begin
			win[n] = b;
			n++;
		end
		while (pos < n && glyph_total < glyph_limit) begin
			avail = n - pos;
			used = 1;
			ok = 1'b1;
			cp = 21'(win[pos]);
			len = lead_length(win[pos]);
			if (len != 0) begin
				for (int i = 1; i < len && i < avail; i++)
					if (win[pos + i][7:6] != 2'b10) begin
						ok = 1'b0;
						break;
					end
				if (ok && avail < len && !term)
					break;
				if (ok && avail >= len) begin
					used = len;
					case (len)
						2: cp = 21'({win[pos][4:0], win[pos + 1][5:0]});
						3: cp = 21'({win[pos][3:0], win[pos + 1][5:0], win[pos + 2][5:0]});
						default: cp = {win[pos][2:0], win[pos + 1][5:0], win[pos + 2][5:0],
							win[pos + 3][5:0]};
					endcase
				end
			end
			r.glyph = glyph_of(cp);
			r.is_terminator = 1'b0;
			r.glyph_count = '0;
			glyphs_due.push_back(r);
			glyph_total++;
			pos += used;
		end
		if (term || glyph_total >= glyph_limit) begin
			held_count = 0;
		end else begin
			held_count = n - pos;
			for (int i = 0; i < held_count; i++)
				held_bytes[i] = win[pos + i];
		end
		if (term) begin
			r.glyph = '0;
			r.is_terminator = 1'b1;
			r.glyph_count = glyph_total;
			glyphs_due.push_back(r);
			glyph_total = '0;
		end
	endtask

	always @(posedge clk) begin : check_results
		u2g_pkg::result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (glyphs_due.size() == 0) begin
					$error("unexpected result: glyph %0h is_terminator %0b glyph_count %0d",
						glyph, is_terminator, glyph_count);
					bad_results++;
				end else begin
					want = glyphs_due.pop_front();
					if (glyph !== want.glyph) begin
						$error("glyph: expected %0h, got %0h", want.glyph, glyph);
						bad_results++;
					end
					if (is_terminator !== want.is_terminator) begin
						$error("is_terminator: expected %0b, got %0b",
							want.is_terminator, is_terminator);
						bad_results++;
					end
					if (glyph_count !== want.glyph_count) begin
						$error("glyph_count: expected %0d, got %0d",
							want.glyph_count, glyph_count);
						bad_results++;
					end
				end
				pop_wait = $urandom_range(0, pop_gap_max);
				if (pop_wait != 0)
					pop <= 1'b0;
			end else if (!pop) begin
				if (pop_wait <= 1)
					pop <= 1'b1;
				else
					pop_wait--;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (full);
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] seq [$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// hold off until every glyph is back and the engine has gone quiet
	task automatic settle();
		push <= 1'b0;
		while (glyphs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input u2g_pkg::reg_index_t idx, input logic [15:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			u2g_pkg::REG_NORDIC_ENABLE: nordic_on = value[0];
			u2g_pkg::REG_MAX_GLYPHS:    glyph_limit = value;
			default: glyph_codes[int'(idx) - int'(u2g_pkg::REG_GLYPH_A_UMLAUT)] = value[7:0];
		endcase
	endtask

	task automatic load_settings(input logic nordic, input logic [15:0] limit,
			input logic [47:0] codes);
		logic [15:0] noise;
		noise = 16'($urandom);
		write_reg(u2g_pkg::REG_NORDIC_ENABLE, {noise[15:1], nordic});
		write_reg(u2g_pkg::REG_MAX_GLYPHS, limit);
		for (int i = 0; i < 6; i++)
			write_reg(u2g_pkg::reg_index_t'(int'(u2g_pkg::REG_GLYPH_A_UMLAUT) + i),
				{noise[15:8], codes[i*8 +: 8]});
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_plain_ascii();
		send_bytes('{8'h01, 8'h7F, END_OF_STRING});
		settle();
	endtask

	task automatic test_nordic_letters();
		send_bytes('{8'hC3, 8'hA4, END_OF_STRING});
		settle();
		load_settings(1'b1, 16'd255, 48'h78_56_34_12_FF_00);
		send_bytes('{8'hC3, 8'hA4, 8'hC3, 8'h85, END_OF_STRING});
		settle();
	endtask

	task automatic test_multibyte();
		send_bytes('{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC0, 8'h80,
			END_OF_STRING});
		settle();
	endtask

	task automatic test_broken_sequences();
		send_bytes('{8'hE4, 8'h41, 8'hFF, 8'hE2, 8'h82, END_OF_STRING});
		settle();
	endtask

	task automatic test_glyph_limit();
		write_reg(u2g_pkg::REG_MAX_GLYPHS, 16'd2);
		cfg_wr_en <= 1'b0;
		send_bytes('{8'h41, 8'h42, 8'hC3, END_OF_STRING});
		settle();
		write_reg(u2g_pkg::REG_MAX_GLYPHS, 16'd0);
		cfg_wr_en <= 1'b0;
		send_bytes('{8'h41, END_OF_STRING});
		settle();
		write_reg(u2g_pkg::REG_MAX_GLYPHS, 16'd65534);
		cfg_wr_en <= 1'b0;
		send_bytes('{8'h41, 8'h42});
		settle();
		// lower the limit below the count mid-string
		write_reg(u2g_pkg::REG_MAX_GLYPHS, 16'd1);
		cfg_wr_en <= 1'b0;
		send_bytes('{8'h43, END_OF_STRING});
		settle();
	endtask

	task automatic send_piece();
		int          kind, len, conts, k;
		logic [7:0]  lead;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			send_byte(8'($urandom_range(1, 127)));
		end else if (kind < 55) begin
			k = $urandom_range(0, 5);
			send_byte(8'hC3);
			send_byte({2'b10, NORDIC_POINTS[k][5:0]});
		end else if (kind < 79) begin
			len = (kind < 65) ? 2 : (kind < 73) ? 3 : 4;
			lead = 8'($urandom);
			lead = (len == 2) ? {3'b110, lead[4:0]} :
				(len == 3) ? {4'b1110, lead[3:0]} : {5'b11110, lead[2:0]};
			send_byte(lead);
			for (int i = 1; i < len; i++)
				send_byte({2'b10, 6'($urandom)});
		end else if (kind < 85) begin
			k = $urandom_range(0, 5);
			send_byte(NORDIC_POINTS[k][7:0]);
		end else if (kind < 93) begin
			send_byte(8'($urandom_range(1, 255)));
		end else begin
			len = $urandom_range(2, 4);
			conts = $urandom_range(0, len - 2);
			lead = 8'($urandom);
			lead = (len == 2) ? {3'b110, lead[4:0]} :
				(len == 3) ? {4'b1110, lead[3:0]} : {5'b11110, lead[2:0]};
			send_byte(lead);
			repeat (conts) send_byte({2'b10, 6'($urandom)});
		end
	endtask

	task automatic test_random_strings();
		int          phase_end;
		logic [15:0] limit;
		for (int phase = 0; phase < 5; phase++) begin
			case ($urandom_range(0, 5))
				0: limit = 16'($urandom_range(0, 4));
				1: limit = 16'd255;
				2: limit = 16'd65534;
				default: limit = 16'($urandom_range(5, 40));
			endcase
			load_settings(1'($urandom), limit, {16'($urandom), 32'($urandom)});
			phase_end = bytes_sent + 100;
			while (bytes_sent < phase_end) begin
				send_gap_max = $urandom_range(0, 1) ? 19 : 0;
				pop_gap_max = $urandom_range(0, 1) ? 19 : 0;
				repeat ($urandom_range(0, 12)) send_piece();
				send_byte(END_OF_STRING);
			end
			settle();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		data_byte <= '0;
		pop <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		nordic_on = 1'b0;
		glyph_limit = 16'd255;
		glyph_codes = {6{QUESTION_MARK}};
		held_count = 0;
		glyph_total = '0;
		bad_results = 0;
		bytes_sent = 0;
		send_gap_max = 19;
		pop_gap_max = 19;
		pop_wait = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_ascii();
		test_nordic_letters();
		test_multibyte();
		test_broken_sequences();
		test_glyph_limit();
		test_random_strings();

		settle();
		if (bad_results == 0 && glyphs_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
sv/u2g_pkg.sv
sv/u2g_fifo.sv
sv/u2g_front.sv
sv/u2g_engine.sv
sv/utf8_to_glyph_stream_top.sv
tb/utf8_to_glyph_stream_top_test.sv
